/* src/lsrd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the laser scan range decoder.
package lsrd_pkg;

    // Input beat: one received reply byte.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       reply_start;
    } lsrd_in_t;

    // Output beat: one decoded result.
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [9:0]  sample_index;
        logic [17:0] range_mm;
        logic [6:0]  status_code;
        logic        over_limit;
    } lsrd_out_t;

    // Configuration register set.
    typedef struct packed {
        logic        char_mode;
        logic [9:0]  first_index;
        logic [10:0] sample_count;
        logic [15:0] max_range_mm;
        logic [11:0] min_valid_mm;
        logic [17:0] warn_limit_mm;
        logic [9:0]  warn_last_index;
    } lsrd_cfg_t;

    localparam int CFG_DATA_W  = 18;
    localparam int CFG_INDEX_W = 3;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CHAR_MODE       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_INDEX     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_COUNT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RANGE_MM    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_VALID_MM    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_WARN_LIMIT_MM   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_WARN_LAST_INDEX = 3'd6;

    // Register reset values
    localparam lsrd_cfg_t CFG_RESET = '{
        char_mode:       1'b0,
        first_index:     10'd57,
        sample_count:    11'd654,
        max_range_mm:    16'd4000,
        min_valid_mm:    12'd20,
        warn_limit_mm:   18'd5600,
        warn_last_index: 10'd771
    };

    // Result kinds
    localparam logic [1:0] KIND_READING   = 2'd0;
    localparam logic [1:0] KIND_SCAN_DONE = 2'd1;
    localparam logic [1:0] KIND_STATUS    = 2'd2;
    localparam logic [1:0] KIND_OVERFLOW  = 2'd3;

    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [5:0] CHAR_OFFSET = 6'h30;

endpackage

/* src/lsrd_cfg_regs.sv */
`timescale 1ns / 1ps
// Configuration register file of the laser scan range decoder.
module lsrd_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [lsrd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lsrd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output lsrd_pkg::lsrd_cfg_t              cfg
);
    import lsrd_pkg::*;

    lsrd_cfg_t cfg_reg;
    lsrd_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_CHAR_MODE:       cfg_next.char_mode       = cfg_wdata[0];
                CFG_FIRST_INDEX:     cfg_next.first_index     = cfg_wdata[9:0];
                CFG_SAMPLE_COUNT:    cfg_next.sample_count    = cfg_wdata[10:0];
                CFG_MAX_RANGE_MM:    cfg_next.max_range_mm    = cfg_wdata[15:0];
                CFG_MIN_VALID_MM:    cfg_next.min_valid_mm    = cfg_wdata[11:0];
                CFG_WARN_LIMIT_MM:   cfg_next.warn_limit_mm   = cfg_wdata[17:0];
                CFG_WARN_LAST_INDEX: cfg_next.warn_last_index = cfg_wdata[9:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/lsrd_parser.sv */
`timescale 1ns / 1ps
// Reply parser: parser state and the single-pass decode of one byte.
module lsrd_parser #(
    parameter int MAX_RAW_READINGS = 769
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  lsrd_pkg::lsrd_in_t  item,
    input  lsrd_pkg::lsrd_cfg_t cfg,
    output logic                res_valid,
    output lsrd_pkg::lsrd_out_t res
);
    import lsrd_pkg::*;

    localparam logic [1:0]  PH_HEADER = 2'd0;
    localparam logic [1:0]  PH_STATUS = 2'd1;
    localparam logic [1:0]  PH_DATA   = 2'd2;
    localparam logic [1:0]  PH_DONE   = 2'd3;
    localparam logic [10:0] MAX_RAW   = 11'(MAX_RAW_READINGS);
    localparam logic [9:0]  RAW_SAT   = 10'd1023;

    logic [1:0]  phase_reg, phase_next, phase_cur;
    logic [1:0]  hdr_lines_reg, hdr_lines_next, hdr_lines_cur;
    logic [6:0]  status_reg, status_next, status_cur;
    logic [1:0]  char_cnt_reg, char_cnt_next, char_cnt_cur;
    logic [17:0] accum_reg, accum_next, accum_cur;
    logic [7:0]  pend_char_reg, pend_char_next, pend_char_cur;
    logic        pend_valid_reg, pend_valid_next, pend_valid_cur;
    logic [9:0]  raw_idx_reg, raw_idx_next, raw_idx_cur;
    logic        last_lf_reg, last_lf_next, last_lf_cur;

    // Emitted-reading count for the scan-end beat
    logic [10:0] ec_hi;
    logic [11:0] ec_top;
    logic [11:0] ec_clip;
    logic [11:0] ec_win;
    logic [9:0]  ec_count;

    always_comb begin
        ec_hi  = ({1'b0, raw_idx_cur} > MAX_RAW) ? MAX_RAW : {1'b0, raw_idx_cur};
        ec_top = {2'b00, cfg.first_index} + {1'b0, cfg.sample_count};
        if (!cfg.char_mode) begin
            ec_clip = ({1'b0, ec_hi} > ec_top) ? ec_top : {1'b0, ec_hi};
            ec_win  = (ec_clip > {2'b00, cfg.first_index})
                      ? ec_clip - {2'b00, cfg.first_index} : 12'd0;
        end else begin
            ec_clip = {1'b0, ec_hi};
            ec_win  = ec_clip;
        end
        ec_count = (ec_win > 12'd1023) ? 10'd1023 : ec_win[9:0];
    end

    // Restart applies before the byte is parsed
    always_comb begin
        if (item.reply_start) begin
            phase_cur      = PH_HEADER;
            hdr_lines_cur  = '0;
            status_cur     = '0;
            char_cnt_cur   = '0;
            accum_cur      = '0;
            pend_char_cur  = '0;
            pend_valid_cur = 1'b0;
            raw_idx_cur    = '0;
            last_lf_cur    = 1'b0;
        end else begin
            phase_cur      = phase_reg;
            hdr_lines_cur  = hdr_lines_reg;
            status_cur     = status_reg;
            char_cnt_cur   = char_cnt_reg;
            accum_cur      = accum_reg;
            pend_char_cur  = pend_char_reg;
            pend_valid_cur = pend_valid_reg;
            raw_idx_cur    = raw_idx_reg;
            last_lf_cur    = last_lf_reg;
        end
    end

    logic        is_lf;
    logic [7:0]  feed_char;
    logic        do_feed;
    logic [1:0]  need_chars;
    logic [17:0] acc_shift;
    logic [1:0]  cc_inc;
    logic        complete;
    logic [17:0] value_full;
    logic [11:0] value_12;
    logic        in_window;
    logic [9:0]  win_offset;
    logic        warn_hit;
    logic [1:0]  st_need;
    logic [3:0]  st_digit;
    logic [10:0] st_mul;

    always_comb begin
        is_lf           = (item.rx_byte == CHAR_LF);
        phase_next      = phase_cur;
        hdr_lines_next  = hdr_lines_cur;
        status_next     = status_cur;
        char_cnt_next   = char_cnt_cur;
        accum_next      = accum_cur;
        pend_char_next  = pend_char_cur;
        pend_valid_next = pend_valid_cur;
        raw_idx_next    = raw_idx_cur;
        last_lf_next    = last_lf_cur;
        res_valid       = 1'b0;
        res             = '0;
        feed_char       = item.rx_byte;
        do_feed         = 1'b0;

        st_need  = cfg.char_mode ? 2'd2 : 2'd1;
        st_digit = (item.rx_byte >= CHAR_ZERO && item.rx_byte <= CHAR_NINE)
                   ? item.rx_byte[3:0] : 4'd9;
        st_mul   = {1'b0, status_cur, 3'b000} + {3'b000, status_cur, 1'b0}
                   + {7'd0, st_digit};

        unique case (phase_cur)
            PH_HEADER: begin
                if (is_lf) begin
                    hdr_lines_next = hdr_lines_cur + 2'd1;
                    phase_next     = (hdr_lines_next == 2'd1) ? PH_STATUS : PH_DATA;
                    char_cnt_next  = '0;
                    last_lf_next   = 1'b0;
                end
            end
            PH_STATUS: begin
                if (!is_lf) begin
                    if (char_cnt_cur < st_need) begin
                        status_next = st_mul[6:0];
                    end
                    if (char_cnt_cur != 2'd3) begin
                        char_cnt_next = char_cnt_cur + 2'd1;
                    end
                end else begin
                    char_cnt_next = '0;
                    if (status_cur != '0) begin
                        res_valid       = 1'b1;
                        res.result_kind = KIND_STATUS;
                        res.status_code = status_cur;
                        phase_next      = PH_DONE;
                    end else begin
                        phase_next   = cfg.char_mode ? PH_HEADER : PH_DATA;
                        last_lf_next = 1'b0;
                    end
                end
            end
            PH_DATA: begin
                if (is_lf) begin
                    if (last_lf_cur) begin
                        res_valid        = 1'b1;
                        res.result_kind  = KIND_SCAN_DONE;
                        res.sample_index = ec_count;
                        phase_next       = PH_DONE;
                    end else begin
                        last_lf_next    = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                end else begin
                    last_lf_next = 1'b0;
                    if (!cfg.char_mode) begin
                        pend_valid_next = 1'b0;
                        do_feed         = 1'b1;
                    end else begin
                        // Hold one character back: the last one on a line is the checksum
                        do_feed         = pend_valid_cur;
                        feed_char       = pend_char_cur;
                        pend_char_next  = item.rx_byte;
                        pend_valid_next = 1'b1;
                    end
                end
            end
            default: begin
                // Scan finished or aborted: drop bytes until restart
            end
        endcase

        // Character accumulation and reading completion
        need_chars = cfg.char_mode ? 2'd3 : 2'd2;
        acc_shift  = {accum_cur[11:0], feed_char[5:0] - CHAR_OFFSET};
        cc_inc     = char_cnt_cur + 2'd1;
        complete   = do_feed && (cc_inc >= need_chars);
        value_full = acc_shift;
        value_12   = acc_shift[11:0];
        win_offset = raw_idx_cur - cfg.first_index;
        in_window  = (raw_idx_cur >= cfg.first_index)
                     && ({1'b0, win_offset} < cfg.sample_count);
        warn_hit   = (value_full > cfg.warn_limit_mm)
                     && (raw_idx_cur >= cfg.first_index)
                     && (raw_idx_cur <= cfg.warn_last_index);

        if (do_feed) begin
            if (!complete) begin
                accum_next    = acc_shift;
                char_cnt_next = cc_inc;
            end else begin
                accum_next    = '0;
                char_cnt_next = '0;
                if (raw_idx_cur != RAW_SAT) begin
                    raw_idx_next = raw_idx_cur + 10'd1;
                end
                if ({1'b0, raw_idx_cur} >= MAX_RAW) begin
                    res_valid        = 1'b1;
                    res.result_kind  = KIND_OVERFLOW;
                    res.sample_index = raw_idx_cur;
                    res.range_mm     = cfg.char_mode ? value_full : {6'd0, value_12};
                end else if (!cfg.char_mode) begin
                    if (in_window) begin
                        res_valid        = 1'b1;
                        res.result_kind  = KIND_READING;
                        res.sample_index = win_offset;
                        res.range_mm     = (value_12 < cfg.min_valid_mm)
                                           ? {2'b00, cfg.max_range_mm}
                                           : {6'd0, value_12};
                    end
                end else begin
                    res_valid        = 1'b1;
                    res.result_kind  = KIND_READING;
                    res.sample_index = raw_idx_cur;
                    res.range_mm     = value_full;
                    res.over_limit   = warn_hit;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            hdr_lines_reg  <= '0;
            status_reg     <= '0;
            char_cnt_reg   <= '0;
            accum_reg      <= '0;
            pend_char_reg  <= '0;
            pend_valid_reg <= 1'b0;
            raw_idx_reg    <= '0;
            last_lf_reg    <= 1'b0;
        end else if (step) begin
            phase_reg      <= phase_next;
            hdr_lines_reg  <= hdr_lines_next;
            status_reg     <= status_next;
            char_cnt_reg   <= char_cnt_next;
            accum_reg      <= accum_next;
            pend_char_reg  <= pend_char_next;
            pend_valid_reg <= pend_valid_next;
            raw_idx_reg    <= raw_idx_next;
            last_lf_reg    <= last_lf_next;
        end
    end

endmodule

/* src/laser_scan_range_decoder_core.sv */
`timescale 1ns / 1ps
// Laser scan range decoder: top level with input and result registers.
//
// Feed the sensor's reply one byte per beat on the s_ channel; set
// reply_start on the first byte of each reply to restart the parser.
// Decoded results leave on the m_ channel: readings, a scan-complete beat
// carrying the reading count, a status-error beat, or a too-many-readings
// beat. Most bytes produce no result.
// Configuration is written through cfg_we / cfg_index / cfg_wdata; the user
// must do so only while the block is idle, which the block does not enforce.
// Writes to an index past the last register are ignored. Throughput is one
// byte per cycle unless the receiver stalls. A byte is parsed from the input
// register and its result is loaded into the result register behind m_valid.
// The parser state update and the result register load happen together, set
// by one pass through the decode logic. When the receiver stalls, the result
// register holds and the input register absorbs one more beat before s_ready
// drops. Reset clears the parser to the header phase, empties both registers
// and restores the configuration defaults.
module laser_scan_range_decoder_core #(
    parameter int MAX_RAW_READINGS = 769
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  lsrd_pkg::lsrd_in_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output lsrd_pkg::lsrd_out_t              m_data,
    input  logic                             cfg_we,
    input  logic [lsrd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lsrd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import lsrd_pkg::*;

    lsrd_cfg_t cfg;
    lsrd_in_t  in_data_reg;
    logic      in_valid_reg, in_valid_next;
    lsrd_out_t out_data_reg;
    logic      out_valid_reg, out_valid_next;
    logic      advance;
    logic      step;
    logic      res_valid;
    lsrd_out_t res;

    lsrd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lsrd_parser #(
        .MAX_RAW_READINGS (MAX_RAW_READINGS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .item      (in_data_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance ? (step && res_valid) : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

/* src/lsrd_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the laser scan range decoder, bound to the top level.
module lsrd_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input lsrd_pkg::lsrd_out_t m_data
);
    import lsrd_pkg::*;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // With the result register empty the input side must take a beat
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // Status-error beats carry only the status value
    a_status_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.result_kind == KIND_STATUS |->
            m_data.sample_index == '0 && m_data.range_mm == '0
            && m_data.over_limit == 1'b0 && m_data.status_code != '0)
        else $error("malformed status-error beat");

    // Only status-error beats carry a status code; only readings set the flag
    a_status_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.result_kind != KIND_STATUS |->
            m_data.status_code == '0
            && (m_data.result_kind == KIND_READING || m_data.over_limit == 1'b0))
        else $error("status or flag set on wrong result kind");

endmodule

bind laser_scan_range_decoder_core lsrd_checker u_lsrd_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the laser scan range decoder: reply streams in, decoded beats checked.
module tb;
    import lsrd_pkg::*;

    localparam int RAW_LIMIT      = 769;
    localparam int RUN_LIMIT      = 200000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RX_HOLD_CYCLES = 300;

    typedef enum logic [1:0] {
        RP_HEADER,
        RP_STATUS,
        RP_DATA,
        RP_DONE
    } reply_phase_e;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    lsrd_in_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    lsrd_out_t              m_data;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    laser_scan_range_decoder_core #(
        .MAX_RAW_READINGS(RAW_LIMIT)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // reply bytes waiting to be sent, decoded results waiting to arrive
    lsrd_in_t  rx_bytes_q[$];
    lsrd_out_t decoded_q[$];

    // decoder model state
    lsrd_cfg_t    cfg_shadow  = CFG_RESET;
    reply_phase_e reply_phase = RP_HEADER;
    logic [1:0]   lines_seen  = '0;
    logic [6:0]   status_val  = '0;
    logic [1:0]   chars_held  = '0;
    logic [17:0]  accum       = '0;
    logic [7:0]   held_char   = '0;
    logic         held_ok     = 1'b0;
    logic [9:0]   raw_idx     = '0;
    logic         prev_lf     = 1'b0;

    int n_queued    = 0;
    int n_taken     = 0;
    int n_checked   = 0;
    int n_errors    = 0;
    int n_writes    = 0;
    int cycle_count = 0;
    int hold_left   = 0;
    int kind_seen[4];

    bit quiet         = 1'b0;
    bit stall_rx_req  = 1'b0;
    bit stall_rx_done = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void post_result(logic [1:0] kind, int idx, logic [17:0] rng,
                                        logic [6:0] st, logic ov);
        lsrd_out_t r;
        r.result_kind  = kind;
        r.sample_index = 10'(idx);
        r.range_mm     = rng;
        r.status_code  = st;
        r.over_limit   = ov;
        decoded_q.push_back(r);
    endfunction

    // Shift one six-bit character into the reading being assembled.
    function automatic void take_char(logic [7:0] c);
        int          need;
        int          idx;
        int          first;
        logic [17:0] v;
        logic [11:0] v12;
        logic        ov;
        need  = cfg_shadow.char_mode ? 3 : 2;
        accum = {accum[11:0], c[5:0] - CHAR_OFFSET};
        chars_held = chars_held + 2'd1;
        if (chars_held < need) return;
        v          = accum;
        v12        = v[11:0];
        accum      = '0;
        chars_held = '0;
        idx        = raw_idx;
        first      = int'(cfg_shadow.first_index);
        if (idx >= RAW_LIMIT) begin
            post_result(KIND_OVERFLOW, idx, cfg_shadow.char_mode ? v : {6'd0, v12}, '0, 1'b0);
        end else if (!cfg_shadow.char_mode) begin
            if (idx >= first && idx - first < int'(cfg_shadow.sample_count)) begin
                post_result(KIND_READING, idx - first,
                            (v12 < cfg_shadow.min_valid_mm) ? {2'b00, cfg_shadow.max_range_mm}
                                                            : {6'd0, v12},
                            '0, 1'b0);
            end
        end else begin
            ov = (v > cfg_shadow.warn_limit_mm) && idx >= first &&
                 idx <= int'(cfg_shadow.warn_last_index);
            post_result(KIND_READING, idx, v, '0, ov);
        end
        if (raw_idx != 10'd1023) raw_idx = raw_idx + 10'd1;
    endfunction

    // Advance the reply parser by one accepted byte.
    function automatic void parse_byte(lsrd_in_t beat);
        logic [7:0] b;
        int         d;
        int         hi;
        int         top;
        b = beat.rx_byte;
        if (beat.reply_start) begin
            reply_phase = RP_HEADER;
            lines_seen  = '0;
            status_val  = '0;
            chars_held  = '0;
            accum       = '0;
            held_char   = '0;
            held_ok     = 1'b0;
            raw_idx     = '0;
            prev_lf     = 1'b0;
        end
        case (reply_phase)
            RP_HEADER: begin
                if (b == CHAR_LF) begin
                    lines_seen  = lines_seen + 2'd1;
                    reply_phase = (lines_seen == 2'd1) ? RP_STATUS : RP_DATA;
                    chars_held  = '0;
                    prev_lf     = 1'b0;
                end
            end
            RP_STATUS: begin
                if (b != CHAR_LF) begin
                    if (chars_held < (cfg_shadow.char_mode ? 2 : 1)) begin
                        d = (b >= CHAR_ZERO && b <= CHAR_NINE) ? int'(b - CHAR_ZERO) : 9;
                        status_val = 7'(int'(status_val) * 10 + d);
                    end
                    if (chars_held != 2'd3) chars_held = chars_held + 2'd1;
                end else begin
                    chars_held = '0;
                    if (status_val != '0) begin
                        post_result(KIND_STATUS, 0, '0, status_val, 1'b0);
                        reply_phase = RP_DONE;
                    end else begin
                        reply_phase = cfg_shadow.char_mode ? RP_HEADER : RP_DATA;
                        prev_lf     = 1'b0;
                    end
                end
            end
            RP_DATA: begin
                if (b == CHAR_LF) begin
                    if (prev_lf) begin
                        // count of readings that made it out
                        hi = (raw_idx > RAW_LIMIT) ? RAW_LIMIT : int'(raw_idx);
                        if (!cfg_shadow.char_mode) begin
                            top = int'(cfg_shadow.first_index) + int'(cfg_shadow.sample_count);
                            if (hi > top) hi = top;
                            hi = (hi > int'(cfg_shadow.first_index))
                                 ? hi - int'(cfg_shadow.first_index) : 0;
                        end
                        if (hi > 1023) hi = 1023;
                        post_result(KIND_SCAN_DONE, hi, '0, '0, 1'b0);
                        reply_phase = RP_DONE;
                    end else begin
                        prev_lf = 1'b1;
                        held_ok = 1'b0;
                    end
                end else begin
                    prev_lf = 1'b0;
                    if (!cfg_shadow.char_mode) begin
                        held_ok = 1'b0;
                        take_char(b);
                    end else begin
                        // hold each char one beat so the line checksum drops at LF
                        if (held_ok) take_char(held_char);
                        held_char = b;
                        held_ok   = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic queue_byte(logic [7:0] b, bit st = 1'b0);
        lsrd_in_t t;
        t.rx_byte     = b;
        t.reply_start = st;
        rx_bytes_q.push_back(t);
        n_queued++;
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CHAR_LF);
        return b;
    endfunction

    function automatic logic [7:0] nonzero_char();
        return $urandom_range(0, 1) ? CHAR_ZERO + 8'($urandom_range(1, 9)) : text_byte();
    endfunction

    // Encode a six-bit value, sometimes through an alias with different upper bits.
    function automatic logic [7:0] data_byte(logic [5:0] d);
        logic [7:0] b;
        b = {2'b00, d} + CHAR_ZERO;
        if ($urandom_range(0, 4) == 0) b = b + 8'(64 * $urandom_range(1, 3));
        if (b == CHAR_LF) b = {2'b00, d} + CHAR_ZERO;
        return b;
    endfunction

    function automatic logic [17:0] pick_value();
        logic [17:0] thr;
        logic [17:0] v;
        thr = cfg_shadow.char_mode ? cfg_shadow.warn_limit_mm : 18'(cfg_shadow.min_valid_mm);
        case ($urandom_range(0, 3))
            0: v = 18'($urandom);
            1: v = thr + 18'($urandom_range(0, 2)) - 18'd1;
            2: v = 18'($urandom_range(0, 63));
            default: v = '1;
        endcase
        if (!cfg_shadow.char_mode) v[17:12] = '0;
        return v;
    endfunction

    // Echo line, status line and, in three-char mode after an OK status, the time-stamp line.
    task automatic send_head(bit ok);
        bit m1;
        m1 = cfg_shadow.char_mode;
        if ($urandom_range(0, 9) == 0) begin
            queue_byte(CHAR_LF, 1'b1);
        end else begin
            queue_byte(text_byte(), 1'b1);
            repeat ($urandom_range(0, 6)) queue_byte(text_byte());
            queue_byte(CHAR_LF);
        end
        if (ok) begin
            queue_byte(CHAR_ZERO);
            // three-char status may end after one digit
            if (m1 && $urandom_range(0, 4) != 0) begin
                queue_byte(CHAR_ZERO);
                if ($urandom_range(0, 2) != 0) queue_byte(text_byte());
            end
        end else begin
            if (m1) queue_byte(text_byte());
            queue_byte(nonzero_char());
            if ($urandom_range(0, 1)) queue_byte(text_byte());
        end
        queue_byte(CHAR_LF);
        if (ok && m1) begin
            repeat (4) queue_byte(text_byte());
            queue_byte(CHAR_LF);
        end
    endtask

    // Data lines of n readings, 64 data chars per line.
    task automatic send_values(int n, bit finish, bit tail);
        int          col;
        int          nch;
        logic [17:0] v;
        bit          m1;
        m1  = cfg_shadow.char_mode;
        nch = m1 ? 3 : 2;
        col = 0;
        for (int i = 0; i < n; i++) begin
            v = pick_value();
            for (int k = nch - 1; k >= 0; k--) begin
                queue_byte(data_byte(v[6*k +: 6]));
                col++;
                if (col == 64) begin
                    if (m1) queue_byte(text_byte());
                    queue_byte(CHAR_LF);
                    col = 0;
                end
            end
        end
        if (tail) begin
            queue_byte(data_byte(6'($urandom)));
            col++;
        end
        if (finish) begin
            if (col > 0 || n == 0) begin
                if (m1) queue_byte(text_byte());
                queue_byte(CHAR_LF);
            end
            queue_byte(CHAR_LF);
        end
    endtask

    task automatic send_reply();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            // broken reply: noise with frequent line feeds
            queue_byte(text_byte(), 1'b1);
            repeat ($urandom_range(5, 30))
                queue_byte(($urandom_range(0, 4) == 0) ? CHAR_LF : 8'($urandom));
        end else if (r < 18) begin
            send_head(1'b0);
            repeat ($urandom_range(0, 4)) queue_byte(8'($urandom));
        end else begin
            send_head(1'b1);
            send_values(($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 40), 1'b1,
                        $urandom_range(0, 9) == 0);
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
        end
    endtask

    task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, int val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        case (idx)
            CFG_CHAR_MODE:       cfg_shadow.char_mode       = 1'(val);
            CFG_FIRST_INDEX:     cfg_shadow.first_index     = 10'(val);
            CFG_SAMPLE_COUNT:    cfg_shadow.sample_count    = 11'(val);
            CFG_MAX_RANGE_MM:    cfg_shadow.max_range_mm    = 16'(val);
            CFG_MIN_VALID_MM:    cfg_shadow.min_valid_mm    = 12'(val);
            CFG_WARN_LIMIT_MM:   cfg_shadow.warn_limit_mm   = 18'(val);
            CFG_WARN_LAST_INDEX: cfg_shadow.warn_last_index = 10'(val);
            default: ;
        endcase
        n_writes++;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Wait until every byte is taken and every result is in, then let the pipe settle.
    task automatic wait_idle();
        @(negedge aclk);
        while (rx_bytes_q.size() != 0 || s_valid || decoded_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic run_replies(int budget);
        int stop;
        stop = n_queued + budget;
        while (n_queued < stop) send_reply();
        wait_idle();
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                parse_byte(s_data);
                n_taken++;
            end
            if (!s_valid || s_ready) begin
                if (rx_bytes_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 14)) begin
                    s_valid <= 1'b1;
                    s_data  <= rx_bytes_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with one long hold-off on request
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (stall_rx_req && !stall_rx_done) begin
            m_ready       <= 1'b0;
            hold_left     <= RX_HOLD_CYCLES;
            stall_rx_done <= 1'b1;
        end else begin
            m_ready <= quiet || ($urandom_range(0, 99) >= 14);
        end
    end

    always @(posedge aclk) begin : result_check
        lsrd_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected beat kind=%0d idx=%0d range=%0d status=%0d over=%0d",
                         $time, m_data.result_kind, m_data.sample_index, m_data.range_mm,
                         m_data.status_code, m_data.over_limit);
                n_errors++;
            end else begin
                want = decoded_q.pop_front();
                n_checked++;
                kind_seen[want.result_kind]++;
                if (m_data !== want) begin
                    $display("%0t: mismatch expected kind=%0d idx=%0d range=%0d status=%0d over=%0d",
                             $time, want.result_kind, want.sample_index, want.range_mm,
                             want.status_code, want.over_limit);
                    $display("%0t:            actual kind=%0d idx=%0d range=%0d status=%0d over=%0d",
                             $time, m_data.result_kind, m_data.sample_index, m_data.range_mm,
                             m_data.status_code, m_data.over_limit);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("%0t: timeout, %0d bytes unsent, %0d results outstanding",
                     $time, rx_bytes_q.size(), decoded_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // defaults: status error, non-digit status, empty-window scan with odd bytes
        queue_byte("G", 1'b1);
        queue_byte(CHAR_LF);
        queue_byte("7");
        queue_byte(CHAR_LF);
        queue_byte("x");
        queue_byte(CHAR_LF, 1'b1);
        queue_byte("A");
        queue_byte(CHAR_LF);
        queue_byte(CHAR_LF, 1'b1);
        queue_byte(CHAR_ZERO);
        queue_byte(CHAR_LF);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(CHAR_LF);
        queue_byte(CHAR_LF);
        wait_idle();

        // narrow window, extreme substitution, partial reading at scan end
        set_reg(CFG_FIRST_INDEX, 0);
        set_reg(CFG_SAMPLE_COUNT, 3);
        set_reg(CFG_MAX_RANGE_MM, 65535);
        set_reg(CFG_MIN_VALID_MM, 4095);
        queue_byte(CHAR_LF, 1'b1);
        queue_byte(CHAR_ZERO);
        queue_byte(CHAR_LF);
        queue_byte(8'h6F);
        queue_byte(8'h6F);
        queue_byte("0");
        queue_byte("1");
        queue_byte(8'hFF);
        queue_byte(8'h80);
        queue_byte("Z");
        queue_byte(CHAR_LF);
        queue_byte(CHAR_LF);
        wait_idle();

        // three-char mode, window covering everything, no idling
        quiet = 1'b1;
        set_reg(CFG_CHAR_MODE, 1);
        set_reg(CFG_WARN_LIMIT_MM, 0);
        set_reg(CFG_WARN_LAST_INDEX, 1023);
        run_replies(20);
        quiet = 1'b0;

        set_reg(CFG_FIRST_INDEX, $urandom_range(0, 10));
        set_reg(CFG_WARN_LIMIT_MM, $urandom_range(0, 262143));
        set_reg(CFG_WARN_LAST_INDEX, $urandom_range(5, 30));
        run_replies(20);

        set_reg(CFG_WARN_LIMIT_MM, 262143);
        set_reg(CFG_WARN_LAST_INDEX, 0);
        set_reg(CFG_FIRST_INDEX, 0);
        run_replies(10);

        // two-char mode, random window and thresholds
        set_reg(CFG_CHAR_MODE, 0);
        set_reg(CFG_FIRST_INDEX, $urandom_range(0, 20));
        set_reg(CFG_SAMPLE_COUNT, $urandom_range(1, 30));
        set_reg(CFG_MAX_RANGE_MM, $urandom_range(0, 65535));
        set_reg(CFG_MIN_VALID_MM, $urandom_range(0, 300));
        run_replies(25);

        set_reg(CFG_FIRST_INDEX, 1023);
        set_reg(CFG_SAMPLE_COUNT, 1);
        set_reg(CFG_MIN_VALID_MM, 0);
        run_replies(10);

        // long scan past the raw limit; receiver stalls
        set_reg(CFG_FIRST_INDEX, 0);
        set_reg(CFG_SAMPLE_COUNT, 1024);
        set_reg(CFG_MAX_RANGE_MM, 0);
        set_reg(CFG_MIN_VALID_MM, 4095);
        send_head(1'b1);
        send_values(770, 1'b0, 1'b0);
        stall_rx_req = 1'b1;
        wait_idle();
        // continue the same reply in three-char mode, leave a char held
        set_reg(CFG_CHAR_MODE, 1);
        send_values(2, 1'b0, 1'b0);
        queue_byte(data_byte(6'($urandom)));
        wait_idle();
        // back to two-char mode: held char drops, then close the scan
        set_reg(CFG_CHAR_MODE, 0);
        send_values(1, 1'b1, 1'b1);
        wait_idle();

        $display("Fed %0d reply bytes over %0d register writes; checked %0d result beats",
                 n_taken, n_writes, n_checked);
        $display("Readings %0d, scan ends %0d, status errors %0d, over-count %0d",
                 kind_seen[KIND_READING], kind_seen[KIND_SCAN_DONE],
                 kind_seen[KIND_STATUS], kind_seen[KIND_OVERFLOW]);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
src/lsrd_pkg.sv
src/lsrd_cfg_regs.sv
src/lsrd_parser.sv
src/laser_scan_range_decoder_core.sv
src/lsrd_checker.sv
tb/tb.sv
